### design/lcdseq_pkg.sv
// ----------------------------------------------------------------------------
// lcdseq_pkg
// shared types, codes and the initialisation table of the lcd sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package lcdseq_pkg;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_INIT  = 3'd1,
      OP_ADDR  = 3'd2,
      OP_CHAR  = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   localparam logic [1:0] CSR_INIT_DELAY  = 2'd0;
   localparam logic [1:0] CSR_WRITE_DELAY = 2'd1;
   localparam logic [1:0] CSR_CLEAR_DELAY = 2'd2;

   localparam logic [15:0] INIT_DELAY_RESET  = 16'd5000;
   localparam logic [15:0] WRITE_DELAY_RESET = 16'd1000;
   localparam logic [15:0] CLEAR_DELAY_RESET = 16'd1520;

   localparam logic [11:0] PIN_EN     = 12'h800;
   localparam logic [11:0] CLEAR_WORD = 12'h801;
   localparam logic [3:0]  ADDR_CTRL  = 4'h9;
   localparam logic [3:0]  CHAR_CTRL  = 4'hB;

   // classified item as it travels from front to back
   typedef struct packed {
      op_type      op;
      logic [11:0] word;
   } entry_type;

   typedef struct packed {
      logic [15:0] init_delay;
      logic [15:0] write_delay;
      logic [15:0] clear_delay;
   } delays_type;

   function automatic logic [11:0] init_word(input logic [3:0] idx);
      logic [11:0] w;
      case (idx)
         4'd0:    w = 12'h838;
         4'd1:    w = 12'h038;
         4'd2:    w = 12'h838;
         4'd3:    w = 12'h038;
         4'd4:    w = 12'h838;
         4'd5:    w = 12'h038;
         4'd6:    w = 12'h838;
         4'd7:    w = 12'h038;
         4'd8:    w = 12'h801;
         4'd9:    w = 12'h001;
         4'd10:   w = 12'h80C;
         4'd11:   w = 12'h00C;
         4'd12:   w = 12'h906;
         4'd13:   w = 12'h106;
         default: w = 12'h000;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

### design/char_lcd_command_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_command_sequencer
// command sequencer for an 8-bit character lcd pin word
// ----------------------------------------------------------------------------
// usage
// - req channel carries one command per transfer: tick, init, set address,
//   write character or clear; row, col and char_code go with it
// - rsp channel carries one pin word per transfer, flagged op_done on the
//   last write of a command and rejected when a command hit a busy block
// - ticks while idle and opcodes five to seven give no rsp transfer
// - csr port sets init, write and clear delays in ticks, write any time idle
// - throughput: one req transfer per cycle while the rsp side is not stalled
// - a req transfer passes through the front queue and then the sequencer
//   result register before the earliest rsp transfer
// - a stalled rsp fills the two-entry queue, after which req_ready drops;
//   the front and back stall independently of each other
// - reset clears the queue, the sequencer state and the result valid flag and
//   loads the delays with 5000, 1000 and 1520 ticks
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_command_sequencer #(
   parameter int INIT_WORDS = 14
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_opcode,
   input  wire logic        req_row,
   input  wire logic [5:0]  req_col,
   input  wire logic [7:0]  req_char_code,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [11:0]      rsp_lcd_pins,
   output logic             rsp_op_done,
   output logic             rsp_rejected,
   // register writes
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   lcdseq_pkg::delays_type delays_ff, delays_in;
   lcdseq_pkg::entry_type  push_entry;
   lcdseq_pkg::entry_type  head;
   logic                   push;
   logic                   pop;
   logic                   q_full;
   logic                   q_not_empty;
   logic [1:0]             q_count;

   // delay registers, an index beyond the list is ignored
   always_comb begin
      delays_in = delays_ff;
      if (csr_wr_en) begin
         case (csr_index)
            lcdseq_pkg::CSR_INIT_DELAY:  delays_in.init_delay  = csr_wdata;
            lcdseq_pkg::CSR_WRITE_DELAY: delays_in.write_delay = csr_wdata;
            lcdseq_pkg::CSR_CLEAR_DELAY: delays_in.clear_delay = csr_wdata;
            default:                     delays_in = delays_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delays_ff.init_delay  <= lcdseq_pkg::INIT_DELAY_RESET;
         delays_ff.write_delay <= lcdseq_pkg::WRITE_DELAY_RESET;
         delays_ff.clear_delay <= lcdseq_pkg::CLEAR_DELAY_RESET;
      end else begin
         delays_ff <= delays_in;
      end
   end

   // front: classify and build the en-high word
   lcdseq_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_char_code (req_char_code),
      .q_full        (q_full),
      .q_push        (push),
      .q_entry       (push_entry)
   );

   // decoupling queue
   lcdseq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (head),
      .count      (q_count)
   );

   // back: sequencing and result register
   lcdseq_back #(
      .INIT_WORDS (INIT_WORDS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .delays       (delays_ff),
      .q_not_empty  (q_not_empty),
      .q_head       (head),
      .q_pop        (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_lcd_pins (rsp_lcd_pins),
      .rsp_op_done  (rsp_op_done),
      .rsp_rejected (rsp_rejected)
   );

   // a dropped command never also ends one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_op_done && rsp_rejected))
      else $error("result both done and rejected");

   // a rejection carries an all-zero pin word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rejected) |-> (rsp_lcd_pins == 12'h000))
      else $error("rejection with non-zero pins");

   // queue occupancy stays within its depth
   assert property (@(posedge clock) disable iff (reset)
      q_count != 2'd3)
      else $error("queue count overflow");

   // no push into a full queue
   assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push)
      else $error("push into full queue");

endmodule

`default_nettype wire

### design/lcdseq_front.sv
// ----------------------------------------------------------------------------
// lcdseq_front
// accepts commands, drops unknown opcodes and builds the en-high pin word
// ----------------------------------------------------------------------------
`default_nettype none

module lcdseq_front (
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [2:0]            req_opcode,
   input  wire logic                  req_row,
   input  wire logic [5:0]            req_col,
   input  wire logic [7:0]            req_char_code,
   input  wire logic                  q_full,
   output logic                       q_push,
   output lcdseq_pkg::entry_type      q_entry
);

   logic [6:0] addr;
   logic       known;

   assign addr = {req_row, 6'b0} + {1'b0, req_col};

   always_comb begin
      known        = 1'b1;
      q_entry.op   = lcdseq_pkg::OP_TICK;
      q_entry.word = '0;
      case (req_opcode)
         lcdseq_pkg::OP_TICK: begin
            q_entry.op = lcdseq_pkg::OP_TICK;
         end
         lcdseq_pkg::OP_INIT: begin
            q_entry.op = lcdseq_pkg::OP_INIT;
         end
         lcdseq_pkg::OP_ADDR: begin
            q_entry.op   = lcdseq_pkg::OP_ADDR;
            q_entry.word = {lcdseq_pkg::ADDR_CTRL, 1'b1, addr};
         end
         lcdseq_pkg::OP_CHAR: begin
            q_entry.op   = lcdseq_pkg::OP_CHAR;
            q_entry.word = {lcdseq_pkg::CHAR_CTRL, req_char_code};
         end
         lcdseq_pkg::OP_CLEAR: begin
            q_entry.op   = lcdseq_pkg::OP_CLEAR;
            q_entry.word = lcdseq_pkg::CLEAR_WORD;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   assign req_ready = !q_full;
   // opcodes five to seven never reach the back end
   assign q_push    = req_valid && req_ready && known;

endmodule

`default_nettype wire

### design/lcdseq_queue.sv
// ----------------------------------------------------------------------------
// lcdseq_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module lcdseq_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire lcdseq_pkg::entry_type push_entry,
   input  wire logic                  pop,
   output logic                       full,
   output logic                       not_empty,
   output lcdseq_pkg::entry_type      head,
   output logic [1:0]                 count
);

   lcdseq_pkg::entry_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### design/lcdseq_back.sv
// ----------------------------------------------------------------------------
// lcdseq_back
// command sequencer: tick counting, pin word edges and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module lcdseq_back #(
   parameter int INIT_WORDS = 14
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lcdseq_pkg::delays_type delays,
   input  wire logic                  q_not_empty,
   input  wire lcdseq_pkg::entry_type q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [11:0]                rsp_lcd_pins,
   output logic                       rsp_op_done,
   output logic                       rsp_rejected
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INIT,
      ST_WRITE,
      ST_CLEAR
   } state_type;

   localparam logic [4:0] WORDS = 5'(INIT_WORDS);

   state_type   state_ff, state_in;
   logic        phase_ff, phase_in;
   logic [3:0]  index_ff, index_in;
   logic [15:0] count_ff, count_in;
   logic [11:0] held_ff, held_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [11:0] pins_ff, pins_in;
   logic        done_ff, done_in;
   logic        rej_ff, rej_in;

   logic [15:0] delay_raw;
   logic [16:0] delay_eff;
   logic [16:0] next_count;
   logic [11:0] table_word;
   logic        last_word;
   logic        emit;

   assign q_pop = q_not_empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      case (state_ff)
         ST_INIT:  delay_raw = delays.init_delay;
         ST_CLEAR: delay_raw = delays.clear_delay;
         default:  delay_raw = delays.write_delay;
      endcase
   end

   // zero delay behaves like one
   assign delay_eff  = (delay_raw == 16'd0) ? 17'd1 : {1'b0, delay_raw};
   assign next_count = {1'b0, count_ff} + 17'd1;
   assign table_word = lcdseq_pkg::init_word(index_ff);
   assign last_word  = ({1'b0, index_ff} + 5'd1) >= WORDS;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      index_in = index_ff;
      count_in = count_ff;
      held_in  = held_ff;
      emit     = 1'b0;
      pins_in  = pins_ff;
      done_in  = done_ff;
      rej_in   = rej_ff;

      if (q_pop) begin
         if (q_head.op == lcdseq_pkg::OP_TICK) begin
            if (state_ff != ST_IDLE) begin
               if (next_count < delay_eff) begin
                  count_in = next_count[15:0];
               end else begin
                  count_in = '0;
                  emit     = 1'b1;
                  rej_in   = 1'b0;
                  if (state_ff == ST_INIT) begin
                     held_in = table_word;
                     pins_in = table_word;
                     done_in = last_word;
                     if (last_word) begin
                        state_in = ST_IDLE;
                        index_in = '0;
                     end else begin
                        index_in = index_ff + 4'd1;
                     end
                  end else if (!phase_ff) begin
                     phase_in = 1'b1;
                     pins_in  = held_ff;
                     done_in  = 1'b0;
                  end else begin
                     phase_in = 1'b0;
                     state_in = ST_IDLE;
                     pins_in  = held_ff & ~lcdseq_pkg::PIN_EN;
                     done_in  = 1'b1;
                  end
               end
            end
         end else if (state_ff != ST_IDLE) begin
            // busy: drop and report
            emit    = 1'b1;
            pins_in = '0;
            done_in = 1'b0;
            rej_in  = 1'b1;
         end else begin
            count_in = '0;
            phase_in = 1'b0;
            if (q_head.op == lcdseq_pkg::OP_INIT) begin
               held_in = lcdseq_pkg::init_word(4'd0);
               emit    = 1'b1;
               pins_in = lcdseq_pkg::init_word(4'd0);
               rej_in  = 1'b0;
               if (WORDS <= 5'd1) begin
                  index_in = '0;
                  done_in  = 1'b1;
               end else begin
                  state_in = ST_INIT;
                  index_in = 4'd1;
                  done_in  = 1'b0;
               end
            end else begin
               held_in  = q_head.word;
               state_in = (q_head.op == lcdseq_pkg::OP_CLEAR) ? ST_CLEAR : ST_WRITE;
            end
         end
      end

      if (q_pop) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 1'b0;
         index_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         index_ff     <= index_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      held_ff <= held_in;
      pins_ff <= pins_in;
      done_ff <= done_in;
      rej_ff  <= rej_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_lcd_pins = pins_ff;
   assign rsp_op_done  = done_ff;
   assign rsp_rejected = rej_ff;

endmodule

`default_nettype wire
